### hw/rtl/dlr_pkg.sv
// Shared types and constants for the DDA line rasteriser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dlr_pkg;

  // Coordinate and screen-size widths
  localparam int COORD_BITS = 14;
  localparam int DIM_W      = 13;
  localparam int COLOR_W    = 32;

  // Error term holds values below four times the major span
  localparam int ERR_W      = COORD_BITS + 2;
  // Width for unsigned compare of a coordinate against a screen size
  localparam int CMP_W      = COORD_BITS + DIM_W;

  // Queue geometry shared by the command and result queues
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;
  localparam int CNT_W       = 2;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // Input action codes
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  // Classified command passed from front to back
  typedef struct packed {
    logic                         is_load;
    logic                         major_is_x;
    logic                         maj_neg;
    logic                         min_neg;
    logic signed [COORD_BITS-1:0] origin_maj;
    logic signed [COORD_BITS-1:0] origin_min;
    logic signed [COORD_BITS-1:0] target_maj;
    logic        [COORD_BITS-1:0] dmaj_abs;
    logic        [COORD_BITS-1:0] dmin_abs;
    logic        [COLOR_W-1:0]    color;
  } cmd_t;

  // Screen bounds handed to the back end
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // One produced pixel
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [COLOR_W-1:0]    color;
    logic                         visible;
    logic                         last;
  } pix_t;

endpackage

### hw/rtl/dda_line_rasterizer_core.sv
// Top level of the DDA line rasteriser: screen-size registers, front end
// and back end. Depends on dlr_pkg, dlr_front and dlr_back.
`timescale 1ns / 1ps

// Draws straight segments one pixel per clock. A load item (action 0) stores
// both endpoints and a colour and replaces any segment in progress; each step
// item (action 1) then yields the next pixel, from the start point to the end
// point inclusive, with the final one flagged last; a step with no segment in
// progress yields nothing. Pixels are flagged visible when 0 <= x < width and
// 0 <= y < height. Both sides behave as queues: the front holds a two-entry
// command queue and the back a two-entry result queue, so one item is taken
// every clock while results are being drained, and a step item's pixel is
// registered in the command queue and then the result queue before it shows
// on the output. Throughput is set by the back end's segment walker, which
// retires one command per clock; it stalls only when the result queue is
// full. Write the screen size only while no item is in flight.
module dda_line_rasterizer_core import dlr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DIM_W-1:0]             cfg_data,
  // Input queue side
  input  logic                         push,
  output logic                         full,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic        [COLOR_W-1:0]    in_color,
  // Result queue side
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic        [COLOR_W-1:0]    out_pixel_color,
  output logic                         out_visible,
  output logic                         out_last
);

  logic [DIM_W-1:0] screen_width_r, screen_height_r;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  dims_t            dims;
  pix_t             pix;

  // Screen-size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims.width    = screen_width_r;
  assign dims.height   = screen_height_r;

  dlr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_action  (in_action),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_color   (in_color),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  dlr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .dims      (dims),
    .empty     (empty),
    .pop       (pop),
    .pix       (pix)
  );

  // Present the oldest result
  assign out_pixel_x     = pix.x;
  assign out_pixel_y     = pix.y;
  assign out_pixel_color = pix.color;
  assign out_visible     = pix.visible;
  assign out_last        = pix.last;

endmodule

### hw/rtl/dlr_front.sv
// Front end: accepts items, classifies segments and queues commands.
// Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_front import dlr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic        [COLOR_W-1:0]    in_color,
  output logic                         cmd_valid,
  output cmd_t                         cmd,
  input  logic                         cmd_pop
);

  logic signed [COORD_BITS:0]   dx, dy;
  logic        [COORD_BITS:0]   adx_w, ady_w;
  logic        [COORD_BITS-1:0] adx, ady;
  logic                         major_is_x;
  cmd_t                         cmd_in;

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             wr_en;

  // Classify: signed spans, magnitudes and major axis (ties go y-major)
  always_comb begin
    dx    = $signed({in_end_x[COORD_BITS-1], in_end_x})
          - $signed({in_start_x[COORD_BITS-1], in_start_x});
    dy    = $signed({in_end_y[COORD_BITS-1], in_end_y})
          - $signed({in_start_y[COORD_BITS-1], in_start_y});
    adx_w = dx[COORD_BITS] ? -dx : dx;
    ady_w = dy[COORD_BITS] ? -dy : dy;
    adx   = adx_w[COORD_BITS-1:0];
    ady   = ady_w[COORD_BITS-1:0];
    major_is_x = ady < adx;

    cmd_in            = '0;
    cmd_in.is_load    = (in_action == ACTION_LOAD);
    cmd_in.major_is_x = major_is_x;
    cmd_in.color      = in_color;
    if (major_is_x) begin
      cmd_in.origin_maj = in_start_x;
      cmd_in.origin_min = in_start_y;
      cmd_in.target_maj = in_end_x;
      cmd_in.maj_neg    = dx[COORD_BITS];
      cmd_in.min_neg    = dy[COORD_BITS];
      cmd_in.dmaj_abs   = adx;
      cmd_in.dmin_abs   = ady;
    end else begin
      cmd_in.origin_maj = in_start_y;
      cmd_in.origin_min = in_start_x;
      cmd_in.target_maj = in_end_y;
      cmd_in.maj_neg    = dy[COORD_BITS];
      cmd_in.min_neg    = dx[COORD_BITS];
      cmd_in.dmaj_abs   = ady;
      cmd_in.dmin_abs   = adx;
    end
  end

  // Command queue status
  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr_en     = push && !full;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (cmd_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !cmd_pop) cnt_r <= cnt_r + 1'b1;
      else if (!wr_en && cmd_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_ptr_r] <= cmd_in;
  end

endmodule

### hw/rtl/dlr_back.sv
// Back end: walks the active segment one pixel per step, clips, and
// queues results. Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_back import dlr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  cmd_t                         cmd,
  output logic                         cmd_pop,
  input  dims_t                        dims,
  output logic                         empty,
  input  logic                         pop,
  output pix_t                         pix
);

  // Segment state
  logic                         active_r, active_nxt;
  logic                         major_is_x_r, major_is_x_nxt;
  logic                         maj_neg_r, maj_neg_nxt;
  logic                         min_neg_r, min_neg_nxt;
  logic signed [COORD_BITS-1:0] major_pos_r, major_pos_nxt;
  logic signed [COORD_BITS-1:0] minor_pos_r, minor_pos_nxt;
  logic signed [COORD_BITS-1:0] target_r, target_nxt;
  logic        [ERR_W-1:0]      err_r, err_nxt;
  logic        [ERR_W-1:0]      two_dmaj_r, two_dmaj_nxt;
  logic        [ERR_W-1:0]      two_dmin_r, two_dmin_nxt;
  logic        [COLOR_W-1:0]    color_r, color_nxt;

  // Result queue
  pix_t             oq_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] oq_wr_ptr_r, oq_rd_ptr_r;
  logic [CNT_W-1:0] oq_cnt_r;
  logic             oq_full, oq_pop;

  logic                         emit, last;
  logic        [ERR_W-1:0]      err_sum;
  logic                         minor_carry;
  logic signed [COORD_BITS-1:0] px, py;
  logic        [CMP_W-1:0]      px_u, py_u, w_u, h_u;
  pix_t                         pix_in;

  assign oq_full = (oq_cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (oq_cnt_r == '0);
  assign oq_pop  = pop && !empty;
  assign pix     = oq_r[oq_rd_ptr_r];

  // Retire loads and idle steps at once; a live step waits for queue room
  assign emit    = cmd_valid && !cmd.is_load && active_r && !oq_full;
  assign cmd_pop = cmd_valid && (cmd.is_load || !active_r || !oq_full);

  // Form the current pixel and clip it
  always_comb begin
    px   = major_is_x_r ? major_pos_r : minor_pos_r;
    py   = major_is_x_r ? minor_pos_r : major_pos_r;
    last = (major_pos_r == target_r);
    px_u = {{DIM_W{1'b0}}, px};
    py_u = {{DIM_W{1'b0}}, py};
    w_u  = {{COORD_BITS{1'b0}}, dims.width};
    h_u  = {{COORD_BITS{1'b0}}, dims.height};

    pix_in.x       = px;
    pix_in.y       = py;
    pix_in.color   = color_r;
    pix_in.last    = last;
    pix_in.visible = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
                     (px_u < w_u) && (py_u < h_u);
  end

  // Next segment state: load, or advance the error term by one major step
  always_comb begin
    err_sum     = err_r + two_dmin_r;
    minor_carry = (err_sum >= two_dmaj_r);

    active_nxt     = active_r;
    major_is_x_nxt = major_is_x_r;
    maj_neg_nxt    = maj_neg_r;
    min_neg_nxt    = min_neg_r;
    major_pos_nxt  = major_pos_r;
    minor_pos_nxt  = minor_pos_r;
    target_nxt     = target_r;
    err_nxt        = err_r;
    two_dmaj_nxt   = two_dmaj_r;
    two_dmin_nxt   = two_dmin_r;
    color_nxt      = color_r;

    if (cmd_pop && cmd.is_load) begin
      active_nxt     = 1'b1;
      major_is_x_nxt = cmd.major_is_x;
      maj_neg_nxt    = cmd.maj_neg;
      min_neg_nxt    = cmd.min_neg;
      major_pos_nxt  = cmd.origin_maj;
      minor_pos_nxt  = cmd.origin_min;
      target_nxt     = cmd.target_maj;
      err_nxt        = ERR_W'(cmd.dmaj_abs);
      two_dmaj_nxt   = ERR_W'({cmd.dmaj_abs, 1'b0});
      two_dmin_nxt   = ERR_W'({cmd.dmin_abs, 1'b0});
      color_nxt      = cmd.color;
    end else if (emit) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        major_pos_nxt = maj_neg_r ? major_pos_r - 1'b1 : major_pos_r + 1'b1;
        if (minor_carry) begin
          err_nxt       = err_sum - two_dmaj_r;
          minor_pos_nxt = min_neg_r ? minor_pos_r - 1'b1 : minor_pos_r + 1'b1;
        end else begin
          err_nxt = err_sum;
        end
      end
    end
  end

  // Hold segment control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Hold segment datapath state
  always_ff @(posedge clk) begin
    major_is_x_r <= major_is_x_nxt;
    maj_neg_r    <= maj_neg_nxt;
    min_neg_r    <= min_neg_nxt;
    major_pos_r  <= major_pos_nxt;
    minor_pos_r  <= minor_pos_nxt;
    target_r     <= target_nxt;
    err_r        <= err_nxt;
    two_dmaj_r   <= two_dmaj_nxt;
    two_dmin_r   <= two_dmin_nxt;
    color_r      <= color_nxt;
  end

  // Advance result queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      if (emit) oq_wr_ptr_r <= oq_wr_ptr_r + 1'b1;
      if (oq_pop) oq_rd_ptr_r <= oq_rd_ptr_r + 1'b1;
      if (emit && !oq_pop) oq_cnt_r <= oq_cnt_r + 1'b1;
      else if (!emit && oq_pop) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

  // Hold queued pixels
  always_ff @(posedge clk) begin
    if (emit) oq_r[oq_wr_ptr_r] <= pix_in;
  end

endmodule

### hw/rtl/dlr_checker.sv
// Port-level checks for the DDA line rasteriser, bound to the top level.
// Depends on dlr_pkg and dda_line_rasterizer_core.
`timescale 1ns / 1ps

module dlr_checker import dlr_pkg::*; (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic signed [COORD_BITS-1:0] out_pixel_x,
  input logic signed [COORD_BITS-1:0] out_pixel_y,
  input logic        [COLOR_W-1:0]    out_pixel_color,
  input logic                         out_visible,
  input logic                         out_last
);

  // Reset drains both queues
  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not drained by reset");

  // A waiting result holds until it is transferred
  a_result_holds: assert property (@(posedge clk)
    (rst_n && !empty && !pop) |=>
      (!rst_n || (!empty && $stable(out_pixel_x) && $stable(out_pixel_y) &&
                  $stable(out_pixel_color) && $stable(out_last))))
    else $error("waiting result changed before transfer");

  // A visible pixel never has a negative coordinate
  a_visible_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_visible) |->
      (!out_pixel_x[COORD_BITS-1] && !out_pixel_y[COORD_BITS-1]))
    else $error("visible pixel with negative coordinate");

  // The input side fills only after a transfer in
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full && rst_n))
    else $error("input side went full without a transfer");

endmodule

bind dda_line_rasterizer_core dlr_checker u_dlr_checker (.*);

### dv/dlr_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the DDA line rasteriser: watches the configuration, input
// and result channels, predicts every pixel and compares it on transfer.
// Depends on dlr_pkg.

module dlr_pixel_checker import dlr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [DIM_W-1:0]             cfg_data,
  input  logic                         push,
  input  logic                         full,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic        [COLOR_W-1:0]    in_color,
  input  logic                         empty,
  input  logic                         pop,
  input  logic signed [COORD_BITS-1:0] out_pixel_x,
  input  logic signed [COORD_BITS-1:0] out_pixel_y,
  input  logic        [COLOR_W-1:0]    out_pixel_color,
  input  logic                         out_visible,
  input  logic                         out_last,
  output int                           mismatch_count,
  output int                           pixels_pending
);

  // Keep the log short when the block is badly broken
  localparam int MAX_REPORTS = 40;

  // Screen bounds as last written
  logic [DIM_W-1:0] bound_w;
  logic [DIM_W-1:0] bound_h;

  // Segment being walked
  logic                         seg_active;
  logic                         seg_x_major;
  logic signed [COORD_BITS-1:0] seg_x0;
  logic signed [COORD_BITS-1:0] seg_y0;
  logic signed [COORD_BITS-1:0] seg_x1;
  logic signed [COORD_BITS-1:0] seg_y1;
  logic signed [COORD_BITS-1:0] walk_pos;
  longint                       walk_err;   // offset walked times minor delta
  logic        [COLOR_W-1:0]    seg_colour;

  // Pixels predicted but not yet transferred, oldest first
  pix_t pixel_q[$];

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Quotient rounded half away from zero; den is never zero here
  function automatic longint round_ratio(longint num, longint den);
    longint q;
    q = (2 * abs_l(num) + abs_l(den)) / (2 * abs_l(den));
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: pixel mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    pix_t   want;
    longint dx, dy, dmaj, dmin, omin, tmaj, minor, px, py, lim_w, lim_h;
    if (!rst_n) begin
      bound_w     = SCREEN_WIDTH_RST;
      bound_h     = SCREEN_HEIGHT_RST;
      seg_active  = 1'b0;
      seg_x_major = 1'b0;
      seg_x0      = '0;
      seg_y0      = '0;
      seg_x1      = '0;
      seg_y1      = '0;
      walk_pos    = '0;
      walk_err    = 0;
      seg_colour  = '0;
      pixel_q.delete();
    end else begin
      // Compare a result transfer with the oldest prediction
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel (%0d,%0d)", out_pixel_x, out_pixel_y));
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_x !== want.x)
            report_mismatch($sformatf("x got %0d want %0d", out_pixel_x, want.x));
          if (out_pixel_y !== want.y)
            report_mismatch($sformatf("y got %0d want %0d", out_pixel_y, want.y));
          if (out_pixel_color !== want.color)
            report_mismatch($sformatf("colour got %h want %h", out_pixel_color, want.color));
          if (out_visible !== want.visible)
            report_mismatch($sformatf("visible got %b want %b at (%0d,%0d)",
                                      out_visible, want.visible, want.x, want.y));
          if (out_last !== want.last)
            report_mismatch($sformatf("last got %b want %b at (%0d,%0d)",
                                      out_last, want.last, want.x, want.y));
        end
      end

      // Track the screen bounds
      if (cfg_we) begin
        if (cfg_index == CFG_SCREEN_WIDTH) bound_w = cfg_data;
        else if (cfg_index == CFG_SCREEN_HEIGHT) bound_h = cfg_data;
      end

      // Input transfer: a load replaces the segment, a step yields a pixel
      if (push && !full) begin
        if (in_action == ACTION_LOAD) begin
          seg_x0      = in_start_x;
          seg_y0      = in_start_y;
          seg_x1      = in_end_x;
          seg_y1      = in_end_y;
          seg_colour  = in_color;
          dx          = longint'(in_end_x) - longint'(in_start_x);
          dy          = longint'(in_end_y) - longint'(in_start_y);
          seg_x_major = abs_l(dy) < abs_l(dx);
          walk_pos    = seg_x_major ? in_start_x : in_start_y;
          walk_err    = 0;
          seg_active  = 1'b1;
        end else if (seg_active) begin
          dx = longint'(seg_x1) - longint'(seg_x0);
          dy = longint'(seg_y1) - longint'(seg_y0);
          if (seg_x_major) begin
            dmaj = dx;
            dmin = dy;
            omin = seg_y0;
            tmaj = seg_x1;
          end else begin
            dmaj = dy;
            dmin = dx;
            omin = seg_x0;
            tmaj = seg_y1;
          end
          minor = (dmaj == 0) ? omin : omin + round_ratio(walk_err, dmaj);
          if (seg_x_major) begin
            px = walk_pos;
            py = minor;
          end else begin
            px = minor;
            py = walk_pos;
          end
          lim_w        = bound_w;
          lim_h        = bound_h;
          want.x       = px[COORD_BITS-1:0];
          want.y       = py[COORD_BITS-1:0];
          want.color   = seg_colour;
          want.visible = (px >= 0) && (py >= 0) && (px < lim_w) && (py < lim_h);
          want.last    = (walk_pos == tmaj);
          pixel_q.push_back(want);
          // Advance along the major axis, or drop the segment after its end
          if (want.last) begin
            seg_active = 1'b0;
          end else if (dmaj < 0) begin
            walk_pos = walk_pos - 14'sd1;
            walk_err = walk_err - dmin;
          end else begin
            walk_pos = walk_pos + 14'sd1;
            walk_err = walk_err + dmin;
          end
        end
      end
    end
    pixels_pending = pixel_q.size();
  end

endmodule

### dv/tb_dda_line_rasterizer_core.sv
`timescale 1ns / 1ps
// Testbench top for the DDA line rasteriser: clock, reset, segment stimulus,
// screen-size phases and verdict. Depends on dlr_pkg and dlr_pixel_checker.

module tb_dda_line_rasterizer_core import dlr_pkg::*; ();

  localparam int ITEMS_PER_PHASE = 190;
  localparam int PHASES          = 6;
  // Cycles for a load still inside the block to clear both queues
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  // Longest honest quiet spell is a receiver burst plus a sender burst plus
  // a settle
  localparam int STALL_LIMIT     = 1000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [DIM_W-1:0]             cfg_data;
  logic                         push;
  logic                         full;
  logic                         in_action;
  logic signed [COORD_BITS-1:0] in_start_x;
  logic signed [COORD_BITS-1:0] in_start_y;
  logic signed [COORD_BITS-1:0] in_end_x;
  logic signed [COORD_BITS-1:0] in_end_y;
  logic        [COLOR_W-1:0]    in_color;
  logic                         empty;
  logic                         pop;
  logic signed [COORD_BITS-1:0] out_pixel_x;
  logic signed [COORD_BITS-1:0] out_pixel_y;
  logic        [COLOR_W-1:0]    out_pixel_color;
  logic                         out_visible;
  logic                         out_last;
  int                           mismatch_count;
  int                           pixels_pending;

  bit          steady_run;     // no idling on either side
  int          phase_items;
  int unsigned stall_cycles;

  dda_line_rasterizer_core DUT (.*);

  dlr_pixel_checker u_checker (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random bursts of back-pressure, none in the steady part
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady_run && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 8191) return 8191;
    if (v < -8192) return -8192;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  function automatic int near_limit();
    return $urandom_range(0, 1) ? 8191 - int'($urandom_range(0, 30))
                                : -8192 + int'($urandom_range(0, 30));
  endfunction

  function automatic int seg_pixels(int sx, int sy, int ex, int ey);
    int ax, ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return ((ax > ay) ? ax : ay) + 1;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(logic action, logic signed [COORD_BITS-1:0] sx,
                           logic signed [COORD_BITS-1:0] sy,
                           logic signed [COORD_BITS-1:0] ex,
                           logic signed [COORD_BITS-1:0] ey,
                           logic [COLOR_W-1:0] colour);
    @(negedge clk);
    push       <= 1'b1;
    in_action  <= action;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    in_color   <= colour;
    do @(posedge clk); while (full);
  endtask

  // Idle the sender now and then, outside the steady part
  task automatic maybe_idle();
    int cycles;
    if (!steady_run && $urandom_range(0, 5) == 0) begin
      cycles = $urandom_range(1, 11);
      @(negedge clk);
      push <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic send_step();
    maybe_idle();
    send_item(ACTION_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
  endtask

  // Load a segment, then issue the given number of steps
  task automatic run_segment(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] colour,
                             int steps);
    maybe_idle();
    send_item(ACTION_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
              COORD_BITS'(ey), colour);
    phase_items += 1 + steps;
    repeat (steps) send_step();
  endtask

  // Hold the sender until every pixel is out and the block has gone quiet
  task automatic settle_block(int cycles);
    @(negedge clk);
    push <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic apply_screen(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    settle_block(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random segment: mostly well formed, some cut short, some stray steps
  task automatic random_segment();
    int kind, sx, sy, ex, ey, span, pixels, steps;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      steps = $urandom_range(1, 3);
      phase_items += steps;
      repeat (steps) send_step();
      return;
    end
    if (kind < 15) begin
      run_segment(any_coord(), any_coord(), any_coord(), any_coord(), $urandom,
                  $urandom_range(0, 6));
      return;
    end
    if (kind < 65) begin
      span = 24;
      sx   = int'($urandom_range(0, 740)) - 40;
      sy   = int'($urandom_range(0, 560)) - 40;
    end else if (kind < 80) begin
      span = 30;
      sx   = near_limit();
      sy   = near_limit();
    end else begin
      span = 100;
      sx   = int'($urandom_range(0, 1000)) - 200;
      sy   = int'($urandom_range(0, 800)) - 200;
    end
    ex     = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
    ey     = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
    pixels = seg_pixels(sx, sy, ex, ey);
    case ($urandom_range(0, 9))
      0: steps = pixels + int'($urandom_range(1, 3));
      1: steps = $urandom_range(0, pixels - 1);
      default: steps = pixels;
    endcase
    run_segment(sx, sy, ex, ey, $urandom, steps);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SCREEN_WIDTH;
    cfg_data   = '0;
    push       = 1'b0;
    in_action  = ACTION_LOAD;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x   = '0;
    in_end_y   = '0;
    in_color   = '0;
    steady_run = 1'b0;
    phase_items = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: step with nothing loaded, then a short x-major line and a
    // step after its end
    send_step();
    run_segment(0, 0, 5, 2, 32'h00A5_5A01, 7);
    // Equal endpoints give one pixel
    run_segment(10, 10, 10, 10, 32'h1234_5678, 1);
    // Negative half rounds away from zero on a y-major line
    run_segment(0, 0, -1, 2, 32'h0000_0000, 3);
    // Widest span, cut short and replaced by a load going the other way
    run_segment(-8192, -8192, 8191, 8191, 32'hFFFF_FFFF, 3);
    run_segment(8191, -8192, 8181, -8190, 32'h8000_0001, 3);
    // Zero width clips everything
    apply_screen(13'd0, 13'd8191);
    run_segment(0, 0, 2, 1, 32'h0F0F_0F0F, 3);
    // One-pixel screen with a diagonal tie, which goes y-major
    apply_screen(13'd1, 13'd1);
    run_segment(-1, -1, 1, 1, 32'hF0F0_F0F0, 3);

    // Random phases over a spread of screen sizes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_screen(13'd8191, 13'd8191);
        1: apply_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
        2: apply_screen(DIM_W'($urandom_range(1, 8191)), DIM_W'($urandom_range(1, 8191)));
        3: apply_screen(DIM_W'($urandom_range(1, 48)), DIM_W'($urandom_range(1, 48)));
        4: apply_screen(13'd1, 13'd8191);
        default: apply_screen(DIM_W'($urandom_range(1, 800)), DIM_W'($urandom_range(1, 800)));
      endcase
      if (ph == PHASES - 1) steady_run = 1'b1;
      phase_items = 0;
      // Long walk across the widest span, cut short
      if (ph == 0) run_segment(-8192, 8191, 8191, -8191, $urandom, 120);
      while (phase_items < ITEMS_PER_PHASE) random_segment();
    end

    settle_block(TAIL_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
